// ===== rtl/core/attribute_run_interval_table_assert.svh =====
// Assertion macros shared by the run interval table RTL.
`ifndef ATTRIBUTE_RUN_INTERVAL_TABLE_ASSERT_SVH
`define ATTRIBUTE_RUN_INTERVAL_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ARIT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ARIT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/arit_pkg.sv =====
// ----------------------------------------------------------------------------
// arit_pkg
// Types and constants shared by the attribute run interval table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arit_pkg;

  localparam int unsigned POS_BITS      = 16;
  localparam int unsigned ATTR_BITS     = 8;
  localparam int unsigned COUNT_BITS    = 5;
  localparam int unsigned MAX_RUNS_DFLT = 16;

  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic                 command;
    logic [POS_BITS-1:0]  range_start;
    logic [POS_BITS-1:0]  range_length;
    logic [ATTR_BITS-1:0] attr_id;
    logic [POS_BITS-1:0]  position;
  } arit_item_t;

  // One result transaction.
  typedef struct packed {
    logic                  found;
    logic [ATTR_BITS-1:0]  found_attr;
    logic                  status;
    logic [COUNT_BITS-1:0] run_count;
  } arit_result_t;

  // One stored run, end exclusive and one bit wider than a position.
  typedef struct packed {
    logic [POS_BITS-1:0]  run_start;
    logic [POS_BITS:0]    run_end;
    logic [ATTR_BITS-1:0] run_attr;
  } arit_run_t;

  // Memory port control.
  typedef struct packed {
    logic rd_en;
    logic rd_bank;
    logic wr_en;
    logic wr_bank;
  } arit_mem_ctl_t;

endpackage

// ===== rtl/core/arit_mem.sv =====
// ----------------------------------------------------------------------------
// arit_mem
// Two-bank run table memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arit_mem #(
  parameter int unsigned MAX_RUNS = arit_pkg::MAX_RUNS_DFLT,
  parameter int unsigned IW       = $clog2(MAX_RUNS)
) (
  input  logic                  clk_i,
  input  arit_pkg::arit_mem_ctl_t ctl_i,
  input  logic [IW-1:0]         rd_idx_i,
  input  logic [IW-1:0]         wr_idx_i,
  input  arit_pkg::arit_run_t   wr_data_i,
  output arit_pkg::arit_run_t   rd_data_o
);
  import arit_pkg::*;

  arit_run_t mem_q [2*MAX_RUNS];
  arit_run_t rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[{ctl_i.wr_bank, wr_idx_i}] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[{ctl_i.rd_bank, rd_idx_i}];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/core/attribute_run_interval_table.sv =====
// ----------------------------------------------------------------------------
// attribute_run_interval_table
// Ordered table of attributed runs with assign and query transactions.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows on res_o, marked by res_valid_o for a single cycle, and the
// receiver cannot stall it. The result appears in the cycle in which busy
// falls, or in the cycle after acceptance when busy never rises. The runs live
// in a two-bank memory with one read and one write port. A query reads the
// active bank one entry at a time until a hit or the last entry, and does not
// raise busy on an empty table. An assign reads each run, writes the runs of
// the new table in order into the other bank while they fit, and then takes a
// finish step. A zero-length assign never raises busy. The banks swap only if
// the new table fits, so a rejected assign leaves the table untouched. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps

module attribute_run_interval_table #(
  parameter int unsigned MAX_RUNS = arit_pkg::MAX_RUNS_DFLT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  arit_pkg::arit_item_t   item_i,
  output logic                   busy,
  output logic                   res_valid_o,
  output arit_pkg::arit_result_t res_o
);
  import arit_pkg::*;

  `include "attribute_run_interval_table_assert.svh"

  localparam int unsigned IW = $clog2(MAX_RUNS);
  localparam int unsigned HW = $clog2(MAX_RUNS + 1);
  localparam int unsigned NW = $clog2(3 * MAX_RUNS + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [POS_BITS:0] POS_LIMIT = {1'b1, {POS_BITS{1'b0}}};

  logic [2:0]         state_q, state_d;
  logic [HW-1:0]      held_q, held_d;
  logic               bank_q, bank_d;
  logic [HW-1:0]      idx_q, idx_d;
  logic [NW-1:0]      n_q, n_d;
  logic               placed_q, placed_d;
  logic [1:0]         j_q, j_d;
  logic [1:0]         k_q, k_d;
  arit_item_t         item_q;
  logic [POS_BITS:0]  end_q;
  arit_run_t          list_q [3];
  arit_run_t          list_d [3];
  logic               res_valid_q, res_valid_d;
  arit_result_t       res_q, res_d;

  arit_mem_ctl_t      mem_ctl;
  logic [IW-1:0]      wr_idx;
  arit_run_t          wr_data;
  arit_run_t          rd_data;
  arit_run_t          new_run;
  logic [POS_BITS:0]  sum;
  logic [HW-1:0]      idx_nx;
  logic [HW+COUNT_BITS-1:0] cnt_ext;
  logic [NW+COUNT_BITS-1:0] n_ext;

  arit_mem #(.MAX_RUNS(MAX_RUNS), .IW(IW)) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_idx_i  (idx_q[IW-1:0]),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // End of the incoming range, saturated when registered, and the run it describes.
  assign sum     = {1'b0, item_i.range_start} + {1'b0, item_i.range_length};
  assign new_run = '{run_start: item_q.range_start, run_end: end_q,
                     run_attr: item_q.attr_id};
  assign idx_nx  = idx_q + HW'(1);
  assign cnt_ext = {{COUNT_BITS{1'b0}}, held_q};
  assign n_ext   = {{COUNT_BITS{1'b0}}, n_q};

  // Sequencer over the run table.
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    bank_d      = bank_q;
    idx_d       = idx_q;
    n_d         = n_q;
    placed_d    = placed_q;
    j_d         = j_q;
    k_d         = k_q;
    list_d      = list_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_ctl     = '{rd_en: 1'b0, rd_bank: bank_q, wr_en: 1'b0, wr_bank: ~bank_q};
    wr_idx      = n_q[IW-1:0];
    wr_data     = list_q[j_q];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          idx_d    = '0;
          n_d      = '0;
          placed_d = 1'b0;
          res_d    = '{found: 1'b0, found_attr: '0, status: STATUS_DONE,
                       run_count: cnt_ext[COUNT_BITS-1:0]};
          if (item_i.command == CMD_QUERY) begin
            if (held_q == '0) begin
              res_valid_d = 1'b1;
            end else begin
              state_d = S_RD;
            end
          end else if (item_i.range_length == '0) begin
            res_valid_d = 1'b1;
          end else if (held_q == '0) begin
            state_d = S_TAIL;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = S_EV;
      end
      S_EV: begin
        if (item_q.command == CMD_QUERY) begin
          if ({1'b0, rd_data.run_start} <= {1'b0, item_q.position} &&
              {1'b0, item_q.position} < rd_data.run_end) begin
            res_d.found      = 1'b1;
            res_d.found_attr = rd_data.run_attr;
            res_valid_d      = 1'b1;
            state_d          = S_IDLE;
          end else if (idx_nx == held_q) begin
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            idx_d   = idx_nx;
            state_d = S_RD;
          end
        end else begin
          // Split the stored run into the pieces that survive around the new one, and place the new run once in order.
          k_d = '0;
          if (rd_data.run_end <= {1'b0, item_q.range_start}) begin
            list_d[0] = rd_data;
            k_d       = 2'd1;
          end else if ({1'b0, rd_data.run_start} >= end_q) begin
            if (!placed_q) begin
              list_d[0] = new_run;
              list_d[1] = rd_data;
              k_d       = 2'd2;
            end else begin
              list_d[0] = rd_data;
              k_d       = 2'd1;
            end
            placed_d = 1'b1;
          end else begin
            if (rd_data.run_start < item_q.range_start) begin
              list_d[k_d] = '{run_start: rd_data.run_start,
                              run_end: {1'b0, item_q.range_start},
                              run_attr: rd_data.run_attr};
              k_d = k_d + 2'd1;
            end
            if (!placed_q) begin
              list_d[k_d] = new_run;
              k_d = k_d + 2'd1;
            end
            if (rd_data.run_end > end_q) begin
              list_d[k_d] = '{run_start: end_q[POS_BITS-1:0],
                              run_end: rd_data.run_end,
                              run_attr: rd_data.run_attr};
              k_d = k_d + 2'd1;
            end
            placed_d = 1'b1;
          end
          j_d = '0;
          if (k_d != '0) begin
            state_d = S_EMIT;
          end else if (idx_nx == held_q) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_nx;
            state_d = S_RD;
          end
        end
      end
      S_EMIT: begin
        mem_ctl.wr_en = (n_q < NW'(MAX_RUNS));
        n_d           = n_q + NW'(1);
        j_d           = j_q + 2'd1;
        if (j_q + 2'd1 == k_q) begin
          if (idx_nx == held_q) begin
            state_d = placed_q ? S_FIN : S_TAIL;
          end else begin
            idx_d   = idx_nx;
            state_d = S_RD;
          end
        end
      end
      S_TAIL: begin
        mem_ctl.wr_en = (n_q < NW'(MAX_RUNS));
        wr_data       = new_run;
        n_d           = n_q + NW'(1);
        state_d       = S_FIN;
      end
      S_FIN: begin
        // Swap banks only when the rebuilt table fits.
        if (n_q > NW'(MAX_RUNS)) begin
          res_d.status = STATUS_FULL;
        end else begin
          bank_d          = ~bank_q;
          held_d          = n_q[HW-1:0];
          res_d.run_count = n_ext[COUNT_BITS-1:0];
        end
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      bank_q      <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      placed_q    <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      bank_q      <= bank_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      placed_q    <= placed_d;
      j_q         <= j_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    list_q <= list_d;
    if (state_q == S_IDLE && start) begin
      item_q <= item_i;
      end_q  <= (sum > POS_LIMIT) ? POS_LIMIT : sum;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `ARIT_ASSERT_ALWAYS(a_held_bound, held_q <= HW'(MAX_RUNS), "run count above table depth")
  `ARIT_ASSERT_IMP(a_full_no_hit, res_valid_q && res_q.status, !res_q.found,
                   "full status together with a query hit")
  `ARIT_ASSERT_IMP(a_swap_only_fin, bank_q != $past(bank_q), $past(state_q) == S_FIN,
                   "bank swap outside the finish step")
  `ARIT_ASSERT_IMP(a_res_ends_item, res_valid_q, state_q == S_IDLE,
                   "result shown while still busy")

endmodule
